// ===== src/buzzer_led_alarm_sequencer_unit_assert.svh =====
// Assertion macros for the buzzer and LED alarm sequencer.
// Used by the port checker; depends on nothing else.
`ifndef BUZZER_LED_ALARM_SEQUENCER_UNIT_ASSERT_SVH
`define BUZZER_LED_ALARM_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BLAS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("alarm sequencer check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is held.
`define BLAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("alarm sequencer check failed: next-cycle rule");

`endif

// ===== src/blas_pkg.sv =====
// Shared types and constants for the buzzer and LED alarm sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package blas_pkg;

    localparam int unsigned CMD_W = 3;
    localparam int unsigned DUR_W = 32;
    localparam int unsigned LAMP_W = 3;
    localparam int unsigned CFG_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 3'd0,
        CMD_ALARM_START = 3'd1,
        CMD_LED_START  = 3'd2,
        CMD_ALARM_STOP = 3'd3,
        CMD_LED_STOP   = 3'd4
    } blas_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUZZ_ON  = 2'd0,
        REG_BUZZ_OFF = 2'd1,
        REG_BLINK    = 2'd2
    } blas_reg_idx_t;

    localparam logic [CFG_W-1:0] BUZZ_ON_RESET  = 16'd2000;
    localparam logic [CFG_W-1:0] BUZZ_OFF_RESET = 16'd1000;
    localparam logic [CFG_W-1:0] BLINK_RESET    = 16'd150;

    localparam logic [DUR_W-1:0] DUR_MAX   = {DUR_W{1'b1}};
    localparam logic [CFG_W-1:0] PHASE_MAX = {CFG_W{1'b1}};

    // One input word as held in the input register.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DUR_W-1:0]  duration_ticks;
        logic [LAMP_W-1:0] lamp_mask;
        logic              blink_enable;
    } blas_word_t;

    // One result word.
    typedef struct packed {
        logic              buzzer_drive;
        logic [LAMP_W-1:0] lamp_pins;
        logic              any_active;
    } blas_result_t;

endpackage

// ===== src/blas_in_reg.sv =====
// Input register stage of the alarm sequencer.
// Depends on blas_pkg for the word type.
`timescale 1ns / 1ps

module blas_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  blas_pkg::blas_word_t s_word,
    input  logic              take,
    output logic              word_valid,
    output blas_pkg::blas_word_t word
);

    logic                 valid_reg;
    logic                 valid_next;
    blas_pkg::blas_word_t word_reg;

    // The stage can load whenever it is empty or its word leaves this cycle.
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

// ===== src/blas_core.sv =====
// Channel state, configuration registers and the per-word update logic.
// Depends on blas_pkg for types, command codes and reset constants.
`timescale 1ns / 1ps

module blas_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [blas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [blas_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          fire,
    input  blas_pkg::blas_word_t          word,
    output blas_pkg::blas_result_t        result_next
);

    logic [blas_pkg::CFG_W-1:0] buzz_on_reg;
    logic [blas_pkg::CFG_W-1:0] buzz_off_reg;
    logic [blas_pkg::CFG_W-1:0] blink_half_reg;

    logic                          alarm_on_reg, alarm_on_next;
    logic                          buzz_high_reg, buzz_high_next;
    logic                          alarm_blinks_reg, alarm_blinks_next;
    logic [blas_pkg::DUR_W-1:0]    alarm_limit_reg, alarm_limit_next;
    logic [blas_pkg::DUR_W-1:0]    alarm_elapsed_reg, alarm_elapsed_next;
    logic [blas_pkg::CFG_W-1:0]    phase_elapsed_reg, phase_elapsed_next;
    logic                          lamp_on_reg, lamp_on_next;
    logic                          lamp_blinks_reg, lamp_blinks_next;
    logic [blas_pkg::DUR_W-1:0]    lamp_limit_reg, lamp_limit_next;
    logic [blas_pkg::DUR_W-1:0]    lamp_elapsed_reg, lamp_elapsed_next;
    logic [blas_pkg::LAMP_W-1:0]   mask_reg, mask_next;
    logic [blas_pkg::LAMP_W-1:0]   pins_reg, pins_next;
    logic [blas_pkg::CFG_W-1:0]    blink_count_reg, blink_count_next;
    logic                          blink_level_reg, blink_level_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buzz_on_reg    <= blas_pkg::BUZZ_ON_RESET;
            buzz_off_reg   <= blas_pkg::BUZZ_OFF_RESET;
            blink_half_reg <= blas_pkg::BLINK_RESET;
        end else if (cfg_wr_en) begin
            case (blas_pkg::blas_reg_idx_t'(cfg_index))
                blas_pkg::REG_BUZZ_ON:  buzz_on_reg    <= cfg_wdata;
                blas_pkg::REG_BUZZ_OFF: buzz_off_reg   <= cfg_wdata;
                blas_pkg::REG_BLINK:    blink_half_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [blas_pkg::CFG_W-1:0] bc_inc;
        logic                       lit;

        alarm_on_next      = alarm_on_reg;
        buzz_high_next     = buzz_high_reg;
        alarm_blinks_next  = alarm_blinks_reg;
        alarm_limit_next   = alarm_limit_reg;
        alarm_elapsed_next = alarm_elapsed_reg;
        phase_elapsed_next = phase_elapsed_reg;
        lamp_on_next       = lamp_on_reg;
        lamp_blinks_next   = lamp_blinks_reg;
        lamp_limit_next    = lamp_limit_reg;
        lamp_elapsed_next  = lamp_elapsed_reg;
        mask_next          = mask_reg;
        pins_next          = pins_reg;
        blink_count_next   = blink_count_reg;
        blink_level_next   = blink_level_reg;
        bc_inc             = blink_count_reg + 16'd1;
        lit                = 1'b1;

        case (blas_pkg::blas_cmd_t'(word.cmd))
            blas_pkg::CMD_TICK: begin
                // Free-running blink phase; a wrapped count also ends a half.
                if (bc_inc >= blink_half_reg || bc_inc == '0) begin
                    blink_count_next = '0;
                    blink_level_next = !blink_level_reg;
                end else begin
                    blink_count_next = bc_inc;
                end

                if (alarm_on_reg) begin
                    if (alarm_elapsed_reg != blas_pkg::DUR_MAX) begin
                        alarm_elapsed_next = alarm_elapsed_reg + 32'd1;
                    end
                    if (phase_elapsed_reg != blas_pkg::PHASE_MAX) begin
                        phase_elapsed_next = phase_elapsed_reg + 16'd1;
                    end
                    if (alarm_elapsed_next >= alarm_limit_reg) begin
                        alarm_on_next      = 1'b0;
                        buzz_high_next     = 1'b0;
                        alarm_blinks_next  = 1'b0;
                        alarm_limit_next   = '0;
                        alarm_elapsed_next = '0;
                        phase_elapsed_next = '0;
                        pins_next          = pins_next & ~mask_reg;
                    end else begin
                        if (buzz_high_reg) begin
                            if (phase_elapsed_next >= buzz_on_reg) begin
                                buzz_high_next     = 1'b0;
                                phase_elapsed_next = '0;
                            end
                        end else if (phase_elapsed_next >= buzz_off_reg) begin
                            buzz_high_next     = 1'b1;
                            phase_elapsed_next = '0;
                        end
                        lit = alarm_blinks_reg ? !blink_level_next : 1'b1;
                        pins_next = lit ? (pins_next | mask_reg) : (pins_next & ~mask_reg);
                    end
                end

                if (lamp_on_reg) begin
                    if (lamp_elapsed_reg != blas_pkg::DUR_MAX) begin
                        lamp_elapsed_next = lamp_elapsed_reg + 32'd1;
                    end
                    if (lamp_elapsed_next >= lamp_limit_reg) begin
                        lamp_on_next      = 1'b0;
                        lamp_blinks_next  = 1'b0;
                        lamp_limit_next   = '0;
                        lamp_elapsed_next = '0;
                        pins_next         = pins_next & ~mask_reg;
                    end else begin
                        lit = lamp_blinks_reg ? !blink_level_next : 1'b1;
                        pins_next = lit ? (pins_next | mask_reg) : (pins_next & ~mask_reg);
                    end
                end
            end
            blas_pkg::CMD_ALARM_START: begin
                alarm_on_next      = 1'b1;
                buzz_high_next     = 1'b1;
                alarm_blinks_next  = word.blink_enable;
                alarm_limit_next   = word.duration_ticks;
                alarm_elapsed_next = '0;
                phase_elapsed_next = '0;
                mask_next          = word.lamp_mask;
                if (!word.blink_enable) begin
                    pins_next = pins_reg | word.lamp_mask;
                end
            end
            blas_pkg::CMD_LED_START: begin
                lamp_on_next      = 1'b1;
                lamp_blinks_next  = word.blink_enable;
                lamp_limit_next   = word.duration_ticks;
                lamp_elapsed_next = '0;
                mask_next         = word.lamp_mask;
                if (!word.blink_enable) begin
                    pins_next = pins_reg | word.lamp_mask;
                end
            end
            blas_pkg::CMD_ALARM_STOP: begin
                alarm_on_next      = 1'b0;
                buzz_high_next     = 1'b0;
                alarm_blinks_next  = 1'b0;
                alarm_limit_next   = '0;
                alarm_elapsed_next = '0;
                phase_elapsed_next = '0;
                pins_next          = pins_reg & ~mask_reg;
            end
            blas_pkg::CMD_LED_STOP: begin
                lamp_on_next      = 1'b0;
                lamp_blinks_next  = 1'b0;
                lamp_limit_next   = '0;
                lamp_elapsed_next = '0;
                pins_next         = pins_reg & ~mask_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_on_reg      <= 1'b0;
            buzz_high_reg     <= 1'b0;
            alarm_blinks_reg  <= 1'b0;
            alarm_limit_reg   <= '0;
            alarm_elapsed_reg <= '0;
            phase_elapsed_reg <= '0;
            lamp_on_reg       <= 1'b0;
            lamp_blinks_reg   <= 1'b0;
            lamp_limit_reg    <= '0;
            lamp_elapsed_reg  <= '0;
            mask_reg          <= '0;
            pins_reg          <= '0;
            blink_count_reg   <= '0;
            blink_level_reg   <= 1'b0;
        end else if (fire) begin
            alarm_on_reg      <= alarm_on_next;
            buzz_high_reg     <= buzz_high_next;
            alarm_blinks_reg  <= alarm_blinks_next;
            alarm_limit_reg   <= alarm_limit_next;
            alarm_elapsed_reg <= alarm_elapsed_next;
            phase_elapsed_reg <= phase_elapsed_next;
            lamp_on_reg       <= lamp_on_next;
            lamp_blinks_reg   <= lamp_blinks_next;
            lamp_limit_reg    <= lamp_limit_next;
            lamp_elapsed_reg  <= lamp_elapsed_next;
            mask_reg          <= mask_next;
            pins_reg          <= pins_next;
            blink_count_reg   <= blink_count_next;
            blink_level_reg   <= blink_level_next;
        end
    end

    assign result_next.buzzer_drive = alarm_on_next && buzz_high_next;
    assign result_next.lamp_pins    = pins_next;
    assign result_next.any_active   = alarm_on_next || lamp_on_next;

endmodule

// ===== src/buzzer_led_alarm_sequencer_unit.sv =====
// Top level of the buzzer and LED alarm sequencer: input register, core, result register.
// Depends on blas_pkg, blas_in_reg and blas_core.
`timescale 1ns / 1ps

//  Channel   Handshake          Word fields
//  --------  -----------------  ---------------------------------------------------
//  s_        s_valid / s_ready  s_cmd, s_duration_ticks, s_lamp_mask, s_blink_enable
//  m_        m_valid / m_ready  m_buzzer_drive, m_lamp_pins, m_any_active
//  cfg_      cfg_wr_en          cfg_index, cfg_wdata (no handshake, no read-back)
//
// Every accepted word yields exactly one result word: it first waits in the
// input register, then passes through the update logic into the result register.
// A new word is accepted in every cycle while results are taken, so the sustained
// rate is one word per clock, set by the single update pass in blas_core.
// Reset (aresetn low at a clock edge) empties both registers, restores the cadence
// and blink defaults and puts both channels to rest with all LEDs dark.
// When m_ready is low the result holds and the input register can still take one
// more word before s_ready falls.
module buzzer_led_alarm_sequencer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [blas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [blas_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [blas_pkg::CMD_W-1:0]     s_cmd,
    input  logic [blas_pkg::DUR_W-1:0]     s_duration_ticks,
    input  logic [blas_pkg::LAMP_W-1:0]    s_lamp_mask,
    input  logic                           s_blink_enable,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_buzzer_drive,
    output logic [blas_pkg::LAMP_W-1:0]    m_lamp_pins,
    output logic                           m_any_active
);

    blas_pkg::blas_word_t   s_word;
    blas_pkg::blas_word_t   word;
    blas_pkg::blas_result_t result_next;
    blas_pkg::blas_result_t result_reg;
    logic                   word_valid;
    logic                   out_free;
    logic                   fire;
    logic                   m_valid_reg;
    logic                   m_valid_next;

    assign s_word.cmd            = s_cmd;
    assign s_word.duration_ticks = s_duration_ticks;
    assign s_word.lamp_mask      = s_lamp_mask;
    assign s_word.blink_enable   = s_blink_enable;

    // The result register is free when empty or when its word is taken now.
    // A word in the input register updates the channel state exactly when it
    // moves into the result register, so no word is applied twice.
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = word_valid && out_free;

    blas_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .take       (fire),
        .word_valid (word_valid),
        .word       (word)
    );

    blas_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fire        (fire),
        .word        (word),
        .result_next (result_next)
    );

    assign m_valid_next = fire || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // The result payload only loads together with a fresh word.
    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_buzzer_drive = result_reg.buzzer_drive;
    assign m_lamp_pins    = result_reg.lamp_pins;
    assign m_any_active   = result_reg.any_active;

endmodule

// ===== src/blas_port_checker.sv =====
// Port-level checks for the alarm sequencer and the bind that attaches them.
// Depends on blas_pkg and buzzer_led_alarm_sequencer_unit_assert.svh.
`timescale 1ns / 1ps
`include "buzzer_led_alarm_sequencer_unit_assert.svh"

module blas_port_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [blas_pkg::CMD_W-1:0]     s_cmd,
    input logic [blas_pkg::DUR_W-1:0]     s_duration_ticks,
    input logic [blas_pkg::LAMP_W-1:0]    s_lamp_mask,
    input logic                           s_blink_enable,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_buzzer_drive,
    input logic [blas_pkg::LAMP_W-1:0]    m_lamp_pins,
    input logic                           m_any_active
);

    // A stalled input keeps its word until it is accepted.
    `BLAS_ASSERT_NEXT(a_input_holds, aclk, aresetn, s_valid && !s_ready,
        s_valid && $stable(s_cmd) && $stable(s_duration_ticks) && $stable(s_lamp_mask) && $stable(s_blink_enable))

    // A stalled result keeps its word.
    `BLAS_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_buzzer_drive) && $stable(m_lamp_pins) && $stable(m_any_active))

    // The buzzer only sounds while a channel is reported active.
    `BLAS_ASSERT_SAME(a_buzz_needs_active, aclk, aresetn, m_valid && m_buzzer_drive,
        m_any_active)

    // With the result register empty the input side is never stalled.
    `BLAS_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

    // No result appears on the first edge after reset.
    `BLAS_ASSERT_SAME(a_empty_after_reset, aclk, aresetn, $past(!aresetn), !m_valid)

endmodule

bind buzzer_led_alarm_sequencer_unit blas_port_checker u_blas_port_checker (.*);

// ===== verif/tb.sv =====
// Self-checking testbench for buzzer_led_alarm_sequencer_unit.
// Depends on blas_pkg and the block's RTL; a scoreboard class predicts every result word.
`timescale 1ns / 1ps

module tb;
    import blas_pkg::*;

    // Command codes 5 to 7 are spare; the block must ignore them.
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 3'd7;
    // Register index 3 selects no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Idle cycles waited after the last result word, to cover any trailing activity.
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_WORDS = 75;
    localparam int MAX_SHOWN = 40;

    // The scoreboard keeps its own copy of the cadence registers and of both
    // channels. Every accepted input word is applied to that copy at once, and
    // the status it leaves behind is queued as the result word the block owes.
    class alarm_status_ledger;
        logic [CFG_W-1:0]  buzz_on_len;
        logic [CFG_W-1:0]  buzz_off_len;
        logic [CFG_W-1:0]  blink_half_len;
        bit                alarm_run;
        bit                buzz_high;
        bit                alarm_blink;
        logic [DUR_W-1:0]  alarm_len;
        logic [DUR_W-1:0]  alarm_age;
        logic [CFG_W-1:0]  buzz_age;
        bit                lamp_run;
        bit                lamp_blink;
        logic [DUR_W-1:0]  lamp_len;
        logic [DUR_W-1:0]  lamp_age;
        logic [LAMP_W-1:0] mask_shared;
        logic [LAMP_W-1:0] pins;
        logic [CFG_W-1:0]  blink_age;
        bit                blink_dark;
        blas_result_t      owed_status[$];
        int unsigned       faults;
        int unsigned       seen;

        function new();
            buzz_on_len = BUZZ_ON_RESET;
            buzz_off_len = BUZZ_OFF_RESET;
            blink_half_len = BLINK_RESET;
            alarm_run = 0;
            buzz_high = 0;
            alarm_blink = 0;
            alarm_len = '0;
            alarm_age = '0;
            buzz_age = '0;
            lamp_run = 0;
            lamp_blink = 0;
            lamp_len = '0;
            lamp_age = '0;
            mask_shared = '0;
            pins = '0;
            blink_age = '0;
            blink_dark = 0;
            faults = 0;
            seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_BUZZ_ON:  buzz_on_len = val;
                REG_BUZZ_OFF: buzz_off_len = val;
                REG_BLINK:    blink_half_len = val;
                default: ;
            endcase
        endfunction

        function int owed();
            return owed_status.size();
        endfunction

        // Only the pins named by the shared mask are touched.
        function void light(bit lit);
            if (lit) begin
                pins = pins | mask_shared;
            end else begin
                pins = pins & ~mask_shared;
            end
        endfunction

        function void halt_alarm();
            alarm_run = 0;
            buzz_high = 0;
            alarm_blink = 0;
            alarm_len = '0;
            alarm_age = '0;
            buzz_age = '0;
            light(0);
        endfunction

        function void halt_lamp();
            lamp_run = 0;
            lamp_blink = 0;
            lamp_len = '0;
            lamp_age = '0;
            light(0);
        endfunction

        function void one_ms_tick();
            // A zero half period makes the level toggle on every tick.
            blink_age = blink_age + 1'b1;
            if (blink_age >= blink_half_len || blink_age == '0) begin
                blink_age = '0;
                blink_dark = !blink_dark;
            end
            if (alarm_run) begin
                if (alarm_age != DUR_MAX) alarm_age = alarm_age + 1'b1;
                if (buzz_age != PHASE_MAX) buzz_age = buzz_age + 1'b1;
                if (alarm_age >= alarm_len) begin
                    halt_alarm();
                end else begin
                    if (buzz_high) begin
                        if (buzz_age >= buzz_on_len) begin
                            buzz_high = 0;
                            buzz_age = '0;
                        end
                    end else if (buzz_age >= buzz_off_len) begin
                        buzz_high = 1;
                        buzz_age = '0;
                    end
                    light(alarm_blink ? !blink_dark : 1'b1);
                end
            end
            if (lamp_run) begin
                if (lamp_age != DUR_MAX) lamp_age = lamp_age + 1'b1;
                if (lamp_age >= lamp_len) begin
                    halt_lamp();
                end else begin
                    light(lamp_blink ? !blink_dark : 1'b1);
                end
            end
        endfunction

        function void take_word(blas_word_t w);
            blas_result_t status;
            case (w.cmd)
                CMD_TICK: one_ms_tick();
                CMD_ALARM_START: begin
                    alarm_run = 1;
                    buzz_high = 1;
                    alarm_blink = w.blink_enable;
                    alarm_len = w.duration_ticks;
                    alarm_age = '0;
                    buzz_age = '0;
                    mask_shared = w.lamp_mask;
                    if (!w.blink_enable) light(1);
                end
                CMD_LED_START: begin
                    lamp_run = 1;
                    lamp_blink = w.blink_enable;
                    lamp_len = w.duration_ticks;
                    lamp_age = '0;
                    mask_shared = w.lamp_mask;
                    if (!w.blink_enable) light(1);
                end
                CMD_ALARM_STOP: halt_alarm();
                CMD_LED_STOP:   halt_lamp();
                default: ;
            endcase
            status.buzzer_drive = alarm_run && buzz_high;
            status.lamp_pins = pins;
            status.any_active = alarm_run || lamp_run;
            owed_status.push_back(status);
        endfunction

        task report(string msg);
            faults++;
            if (faults <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task match_status(logic bd, logic [LAMP_W-1:0] lp, logic act);
            blas_result_t want;
            if (owed_status.size() == 0) begin
                report("result word arrived with no input word outstanding");
                return;
            end
            want = owed_status.pop_front();
            if (bd !== want.buzzer_drive)
                report($sformatf("result %0d buzzer_drive %b, predicted %b",
                                 seen, bd, want.buzzer_drive));
            if (lp !== want.lamp_pins)
                report($sformatf("result %0d lamp_pins %b, predicted %b",
                                 seen, lp, want.lamp_pins));
            if (act !== want.any_active)
                report($sformatf("result %0d any_active %b, predicted %b",
                                 seen, act, want.any_active));
            seen++;
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd;
    logic [DUR_W-1:0]      s_duration_ticks;
    logic [LAMP_W-1:0]     s_lamp_mask;
    logic                  s_blink_enable;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_buzzer_drive;
    logic [LAMP_W-1:0]     m_lamp_pins;
    logic                  m_any_active;

    // While set, neither the sender nor the receiver inserts idle cycles.
    bit no_stall = 0;

    alarm_status_ledger ledger = new();

    buzzer_led_alarm_sequencer_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_duration_ticks (s_duration_ticks),
        .s_lamp_mask      (s_lamp_mask),
        .s_blink_enable   (s_blink_enable),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_buzzer_drive   (m_buzzer_drive),
        .m_lamp_pins      (m_lamp_pins),
        .m_any_active     (m_any_active)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // The run is far shorter than this; reaching it means the block hung.
    initial begin
        #4_000_000;
        $display("buzzer_led_alarm_sequencer_unit regression: fail");
        $finish;
    end

    // Result side. The values sampled here are the ones present at the edge,
    // since the block and this process update through nonblocking assignments.
    // The ready line is dropped at random in roughly 22 percent of cycles while no_stall is clear.
    always @(posedge aclk) begin
        if (m_valid && m_ready) ledger.match_status(m_buzzer_drive, m_lamp_pins, m_any_active);
        m_ready <= no_stall || ($urandom_range(0, 99) >= 22);
    end

    function automatic blas_word_t compose(logic [CMD_W-1:0] code, logic [DUR_W-1:0] dur,
                                           logic [LAMP_W-1:0] mask, logic blink);
        blas_word_t w;
        w.cmd = code;
        w.duration_ticks = dur;
        w.lamp_mask = mask;
        w.blink_enable = blink;
        return w;
    endfunction

    // Mostly ticks, with starts that run out on their own and occasional stops.
    // Durations are short so channels expire often; now and then a full 32-bit
    // value is used so that every bit of the field moves.
    function automatic blas_word_t random_word();
        blas_word_t w;
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(0, 99);
        span = $urandom_range(0, 9);
        if (span < 7) begin
            w.duration_ticks = $urandom_range(0, 40);
        end else if (span < 9) begin
            w.duration_ticks = $urandom_range(0, 400);
        end else begin
            w.duration_ticks = $urandom();
        end
        w.lamp_mask = LAMP_W'($urandom_range(0, 7));
        w.blink_enable = 1'($urandom_range(0, 1));
        if (pick < 60) begin
            w.cmd = CMD_TICK;
        end else if (pick < 70) begin
            w.cmd = CMD_ALARM_START;
        end else if (pick < 80) begin
            w.cmd = CMD_LED_START;
        end else if (pick < 87) begin
            w.cmd = CMD_ALARM_STOP;
        end else if (pick < 94) begin
            w.cmd = CMD_LED_STOP;
        end else begin
            w.cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        end
        return w;
    endfunction

    // Presents one word and returns at the edge that accepts it. Valid stays
    // high on return so that a following word can go out back to back; a gap
    // lowers it exactly once before the idle cycles.
    task automatic send_word(input blas_word_t w);
        int unsigned gap;
        gap = 0;
        if (!no_stall && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 2);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= w.cmd;
        s_duration_ticks <= w.duration_ticks;
        s_lamp_mask <= w.lamp_mask;
        s_blink_enable <= w.blink_enable;
        do @(posedge aclk); while (!s_ready);
        ledger.take_word(w);
    endtask

    // Stops sending and waits until the block has returned every result word.
    task automatic drain();
        s_valid <= 1'b0;
        while (ledger.owed() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        ledger.set_reg(idx, val);
    endtask

    // Registers change only while the block is idle.
    task automatic set_cadence(input logic [CFG_W-1:0] on_len, input logic [CFG_W-1:0] off_len,
                               input logic [CFG_W-1:0] half_len);
        drain();
        write_reg(REG_BUZZ_ON, on_len);
        write_reg(REG_BUZZ_OFF, off_len);
        write_reg(REG_BLINK, half_len);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(input logic [CFG_W-1:0] on_len, input logic [CFG_W-1:0] off_len,
                                input logic [CFG_W-1:0] half_len, input bit calm);
        set_cadence(on_len, off_len, half_len);
        no_stall = calm;
        repeat (PHASE_WORDS) send_word(random_word());
        no_stall = 0;
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_BUZZ_ON;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_cmd <= CMD_TICK;
        s_duration_ticks <= '0;
        s_lamp_mask <= '0;
        s_blink_enable <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words under the reset cadence. A steady LED run lights all
        // pins at once and ends on its third tick.
        send_word(compose(CMD_LED_START, 32'd3, 3'b111, 1'b0));
        repeat (3) send_word(compose(CMD_TICK, '0, '0, 1'b0));
        // A zero-length alarm stops on the first tick after its start; being a
        // blinking start it leaves the pins alone until then.
        send_word(compose(CMD_ALARM_START, 32'd0, 3'b101, 1'b1));
        send_word(compose(CMD_TICK, DUR_MAX, 3'b111, 1'b1));
        // Stopping an idle channel still clears the pins in the kept mask.
        send_word(compose(CMD_ALARM_STOP, '0, '0, 1'b0));
        // Both channels at the longest duration; the second start replaces the mask.
        send_word(compose(CMD_LED_START, DUR_MAX, 3'b010, 1'b1));
        send_word(compose(CMD_ALARM_START, DUR_MAX, 3'b001, 1'b0));
        send_word(compose(CMD_TICK, '0, '0, 1'b0));
        send_word(compose(CMD_LED_STOP, '0, 3'b111, 1'b1));
        // Spare command codes must leave the state untouched.
        send_word(compose(CMD_SPARE_FIRST, DUR_MAX, 3'b111, 1'b1));
        send_word(compose(CMD_SPARE_MID, 32'hA5A5_5A5A, 3'b010, 1'b0));
        send_word(compose(CMD_SPARE_LAST, '0, '0, 1'b1));
        send_word(compose(CMD_ALARM_STOP, '0, '0, 1'b0));
        send_word(compose(CMD_LED_STOP, '0, '0, 1'b0));
        send_word(compose(CMD_TICK, '0, '0, 1'b0));

        // Zero cadence values lie outside the legal range: the buzzer part and
        // the blink level then switch on every tick.
        set_cadence('0, '0, '0);
        send_word(compose(CMD_ALARM_START, 32'd6, 3'b111, 1'b1));
        repeat (4) send_word(compose(CMD_TICK, '0, '0, 1'b0));
        send_word(compose(CMD_LED_START, 32'd2, 3'b011, 1'b0));
        repeat (2) send_word(compose(CMD_TICK, '0, '0, 1'b0));

        // Random phases over a range of cadences, the extremes among them.
        random_phase(16'd3, 16'd2, 16'd2, 0);
        random_phase(16'd1, 16'd1, 16'd1, 0);
        random_phase(PHASE_MAX, PHASE_MAX, PHASE_MAX, 1);
        drain();
        write_reg(REG_SPARE, CFG_W'($urandom_range(0, 65535)));
        cfg_wr_en <= 1'b0;
        random_phase(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 8)),
                     CFG_W'($urandom_range(1, 8)), 0);
        random_phase(BUZZ_ON_RESET, BUZZ_OFF_RESET, BLINK_RESET, 0);
        random_phase(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)),
                     CFG_W'($urandom_range(1, 6)), 0);

        drain();
        if (ledger.faults == 0) begin
            $display("buzzer_led_alarm_sequencer_unit regression: pass");
        end else begin
            $display("buzzer_led_alarm_sequencer_unit regression: fail");
        end
        $finish;
    end

endmodule
